[design/adtd_pkg.sv]
// ----------------------------------------------------------------------------
// adtd_pkg
// Shared types, constants and calendar functions for the date advance block.
// ----------------------------------------------------------------------------
`default_nettype none

package adtd_pkg;

  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned YEAR_W  = 7;
  localparam int unsigned COUNT_W = 14;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Year offset 100 is 2100: divisible by 4 and 100 but not 400.
  // Offset 0 is 2000, which is divisible by 400 and stays a leap year.
  localparam logic [YEAR_W-1:0] YEAR_NOT_LEAP = 7'd100;

  // Command group from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new date and count
    logic step;     // advance one month or finish the day count
    logic publish;  // copy the finished date to the output register
  } adtd_cmd_t;

  // Status group from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
  } adtd_stat_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != YEAR_NOT_LEAP);
  endfunction

  // Length of month m in year y; 0 for month codes outside 1..12.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic [YEAR_W-1:0]  y);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = is_leap(y) ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[design/adtd_datapath.sv]
// ----------------------------------------------------------------------------
// adtd_datapath
// Date registers, month stepping logic and the output holding register.
// ----------------------------------------------------------------------------
`default_nettype none

module adtd_datapath (
  input  wire                              clk,
  input  wire adtd_pkg::adtd_cmd_t         cmd,
  output adtd_pkg::adtd_stat_t             stat,
  input  wire [adtd_pkg::MONTH_W-1:0]      in_start_month,
  input  wire [adtd_pkg::DAY_W-1:0]        in_start_day,
  input  wire [adtd_pkg::YEAR_W-1:0]       in_start_year,
  input  wire [adtd_pkg::COUNT_W-1:0]      in_day_count,
  output logic [adtd_pkg::MONTH_W-1:0]     out_end_month,
  output logic [adtd_pkg::DAY_W-1:0]       out_end_day,
  output logic [adtd_pkg::YEAR_W-1:0]      out_end_year,
  output logic                             out_input_invalid
);
  import adtd_pkg::*;

  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               invalid_r, invalid_nxt;

  logic [DAY_W-1:0]   in_len;
  logic               in_bad;
  logic [DAY_W-1:0]   cur_len;
  logic [DAY_W-1:0]   left;
  logic [COUNT_W-1:0] left_ext;

  assign in_len = month_days(in_start_month, in_start_year);
  assign in_bad = (in_start_month < MONTH_JAN) || (in_start_month > MONTH_DEC) ||
                  (in_start_day == '0) || (in_start_day > in_len);

  assign cur_len  = month_days(month_r, year_r);
  assign left     = cur_len - day_r;
  assign left_ext = {{(COUNT_W-DAY_W){1'b0}}, left};

  always_comb begin
    month_nxt   = month_r;
    day_nxt     = day_r;
    year_nxt    = year_r;
    count_nxt   = count_r;
    invalid_nxt = invalid_r;
    if (cmd.load) begin
      month_nxt   = in_start_month;
      day_nxt     = in_start_day;
      year_nxt    = in_start_year;
      count_nxt   = in_bad ? '0 : in_day_count;
      invalid_nxt = in_bad;
    end else if (cmd.step) begin
      if (count_r > left_ext) begin
        // Consume the rest of this month and land on the first of the next.
        count_nxt = count_r - (left_ext + COUNT_W'(1));
        day_nxt   = DAY_W'(1);
        if (month_r == MONTH_DEC) begin
          month_nxt = MONTH_JAN;
          year_nxt  = year_r + YEAR_W'(1);
        end else begin
          month_nxt = month_r + MONTH_W'(1);
        end
      end else begin
        // Remaining count fits within this month.
        day_nxt   = day_r + count_r[DAY_W-1:0];
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    month_r   <= month_nxt;
    day_r     <= day_nxt;
    year_r    <= year_nxt;
    count_r   <= count_nxt;
    invalid_r <= invalid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_end_month     <= month_r;
      out_end_day       <= day_r;
      out_end_year      <= year_r;
      out_input_invalid <= invalid_r;
    end
  end

  assign stat.count_zero = (count_r == '0);

endmodule

`default_nettype wire

[design/adtd_ctrl.sv]
// ----------------------------------------------------------------------------
// adtd_ctrl
// Sequencer for the date advance: accept, step months, publish the result.
// ----------------------------------------------------------------------------
`default_nettype none

module adtd_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire                      out_ready,
  input  wire adtd_pkg::adtd_stat_t stat,
  output adtd_pkg::adtd_cmd_t      cmd,
  output logic                     busy
);
  import adtd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.publish = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stat.count_zero) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          // Hold the finished date until the output register frees up.
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign busy      = (state_r == ST_RUN);

endmodule

`default_nettype wire

[design/add_days_to_date.sv]
// ----------------------------------------------------------------------------
// add_days_to_date
// Gregorian date advance: start date plus a day count gives the end date.
// ----------------------------------------------------------------------------
// Takes one transaction at a time. The start date and count are loaded,
// then the datapath steps one calendar month per cycle, once per month
// boundary crossed, plus one more step when the count ends inside a month,
// and the result is published once the output register is free. Invalid
// dates (month outside 1..12, day 0 or past the month's end) skip the
// stepping and finish with input_invalid set and the start date echoed.
// A new transaction is taken while the previous result still waits in the
// output register. Years are offsets from 2000 and wrap from 127 to 0.
`default_nettype none

module add_days_to_date (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [adtd_pkg::MONTH_W-1:0]   in_start_month,
  input  wire [adtd_pkg::DAY_W-1:0]     in_start_day,
  input  wire [adtd_pkg::YEAR_W-1:0]    in_start_year,
  input  wire [adtd_pkg::COUNT_W-1:0]   in_day_count,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [adtd_pkg::MONTH_W-1:0]  out_end_month,
  output logic [adtd_pkg::DAY_W-1:0]    out_end_day,
  output logic [adtd_pkg::YEAR_W-1:0]   out_end_year,
  output logic                          out_input_invalid
);
  import adtd_pkg::*;

  adtd_cmd_t  cmd;
  adtd_stat_t stat;
  logic       busy;

  adtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  adtd_datapath u_datapath (
    .clk               (clk),
    .cmd               (cmd),
    .stat              (stat),
    .in_start_month    (in_start_month),
    .in_start_day      (in_start_day),
    .in_start_year     (in_start_year),
    .in_day_count      (in_day_count),
    .out_end_month     (out_end_month),
    .out_end_day       (out_end_day),
    .out_end_year      (out_end_year),
    .out_input_invalid (out_input_invalid)
  );

`ifndef ASSERT_OFF
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (busy && !in_ready))
    else $error("accepted transaction did not start a run");

  a_valid_date_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_input_invalid) |->
      (out_end_month >= MONTH_JAN && out_end_month <= MONTH_DEC &&
       out_end_day != '0))
    else $error("result date out of calendar range");

  a_publish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> !$rose(in_ready) || $stable(out_end_day))
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire
